[src/avradd_pkg.sv]
// Shared types, opcode patterns and decode helpers for the AVR add-group execute unit.
// No dependencies; every other file in src except avradd_ram uses this package.
package avradd_pkg;

   localparam int INSTR_W    = 16;
   localparam int BYTE_W     = 8;
   localparam int REG_COUNT  = 32;
   localparam int REG_AW     = $clog2(REG_COUNT);
   localparam int BANK_DEPTH = REG_COUNT / 2;

   localparam logic [INSTR_W-1:0] ADD_MASK   = 16'b1111110000000000;
   localparam logic [INSTR_W-1:0] ADD_MATCH  = 16'b0000110000000000;
   localparam logic [INSTR_W-1:0] ADC_MATCH  = 16'b0001110000000000;
   localparam logic [INSTR_W-1:0] ADIW_MASK  = 16'b1111111100000000;
   localparam logic [INSTR_W-1:0] ADIW_MATCH = 16'b1001011000000000;

   // ADIW pairs start at r24: address is 11dd0
   localparam logic [1:0] PAIR_BASE = 2'b11;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_ADD,
      OP_ADC,
      OP_ADIW
   } op_type;

   typedef struct packed {
      logic h;
      logic s;
      logic v;
      logic n;
      logic z;
      logic c;
   } flags_type;

   // Register file writes from one instruction: one byte, or a low/high pair
   typedef struct packed {
      logic              lo_en;
      logic [REG_AW-1:0] lo_addr;
      logic [BYTE_W-1:0] lo_data;
      logic              hi_en;
      logic [REG_AW-1:0] hi_addr;
      logic [BYTE_W-1:0] hi_data;
   } wr_type;

   typedef struct packed {
      logic              recognized;
      logic [REG_AW-1:0] dest_index;
      logic [BYTE_W-1:0] low_byte;
      logic [BYTE_W-1:0] high_byte;
      logic              wide;
      flags_type         flags;
   } result_type;

   function automatic op_type decode_op(input logic [INSTR_W-1:0] instr);
      op_type op;
      priority if ((instr & ADD_MASK) == ADD_MATCH) begin
         op = OP_ADD;
      end else if ((instr & ADD_MASK) == ADC_MATCH) begin
         op = OP_ADC;
      end else if ((instr & ADIW_MASK) == ADIW_MATCH) begin
         op = OP_ADIW;
      end else begin
         op = OP_NONE;
      end
      return op;
   endfunction

   // First operand: Rd, or the low register of the ADIW pair
   function automatic logic [REG_AW-1:0] operand_a_addr(input logic [INSTR_W-1:0] instr,
                                                        input op_type op);
      logic [REG_AW-1:0] addr;
      if (op == OP_ADIW) begin
         addr = {PAIR_BASE, instr[5:4], 1'b0};
      end else begin
         addr = {instr[8], instr[7:4]};
      end
      return addr;
   endfunction

   // Second operand: Rr, or the high register of the ADIW pair
   function automatic logic [REG_AW-1:0] operand_b_addr(input logic [INSTR_W-1:0] instr,
                                                        input op_type op);
      logic [REG_AW-1:0] addr;
      if (op == OP_ADIW) begin
         addr = {PAIR_BASE, instr[5:4], 1'b1};
      end else begin
         addr = {instr[9], instr[3:0]};
      end
      return addr;
   endfunction

endpackage

[src/avradd_ram.sv]
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module avradd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read during write returns the old contents
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end

endmodule

[src/avradd_regfile.sv]
// 32 x 8 register file: even and odd banks, per-register valid bits for reset-to-zero,
// and bypass of the last write. Depends on avradd_pkg and avradd_ram.
module avradd_regfile (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                rd_en,
   input  logic [avradd_pkg::REG_AW-1:0]       rd_addr_a,
   input  logic [avradd_pkg::REG_AW-1:0]       rd_addr_b,
   input  avradd_pkg::wr_type                  wr,
   output logic [avradd_pkg::BYTE_W-1:0]       opnd_a,
   output logic [avradd_pkg::BYTE_W-1:0]       opnd_b
);
   import avradd_pkg::*;

   localparam int ROW_W = REG_AW - 1;

   logic              even_wr_en, odd_wr_en;
   logic [ROW_W-1:0]  even_wr_addr, odd_wr_addr;
   logic [BYTE_W-1:0] even_wr_data, odd_wr_data;
   logic [BYTE_W-1:0] even_a, even_b, odd_a, odd_b;

   logic [REG_COUNT-1:0] valid_ff, valid_in;
   logic [REG_AW-1:0]    a_addr_ff, b_addr_ff;
   logic                 a_valid_ff, b_valid_ff;

   logic                 fwd_lo_en_ff, fwd_hi_en_ff;
   logic [REG_AW-1:0]    fwd_lo_addr_ff, fwd_hi_addr_ff;
   logic [BYTE_W-1:0]    fwd_lo_data_ff, fwd_hi_data_ff;

   // Route each written byte to the bank that holds it
   always_comb begin
      even_wr_en   = 1'b0;
      even_wr_addr = '0;
      even_wr_data = '0;
      odd_wr_en    = 1'b0;
      odd_wr_addr  = '0;
      odd_wr_data  = '0;
      if (wr.lo_en && !wr.lo_addr[0]) begin
         even_wr_en   = 1'b1;
         even_wr_addr = wr.lo_addr[REG_AW-1:1];
         even_wr_data = wr.lo_data;
      end
      if (wr.lo_en && wr.lo_addr[0]) begin
         odd_wr_en   = 1'b1;
         odd_wr_addr = wr.lo_addr[REG_AW-1:1];
         odd_wr_data = wr.lo_data;
      end
      if (wr.hi_en && !wr.hi_addr[0]) begin
         even_wr_en   = 1'b1;
         even_wr_addr = wr.hi_addr[REG_AW-1:1];
         even_wr_data = wr.hi_data;
      end
      if (wr.hi_en && wr.hi_addr[0]) begin
         odd_wr_en   = 1'b1;
         odd_wr_addr = wr.hi_addr[REG_AW-1:1];
         odd_wr_data = wr.hi_data;
      end
   end

   avradd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BANK_DEPTH)
   ) u_even_bank (
      .clock     (clock),
      .wr_en     (even_wr_en),
      .wr_addr   (even_wr_addr),
      .wr_data   (even_wr_data),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a[REG_AW-1:1]),
      .rd_addr_b (rd_addr_b[REG_AW-1:1]),
      .rd_data_a (even_a),
      .rd_data_b (even_b)
   );

   avradd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BANK_DEPTH)
   ) u_odd_bank (
      .clock     (clock),
      .wr_en     (odd_wr_en),
      .wr_addr   (odd_wr_addr),
      .wr_data   (odd_wr_data),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a[REG_AW-1:1]),
      .rd_addr_b (rd_addr_b[REG_AW-1:1]),
      .rd_data_a (odd_a),
      .rd_data_b (odd_b)
   );

   always_comb begin
      valid_in = valid_ff;
      if (wr.lo_en) begin
         valid_in[wr.lo_addr] = 1'b1;
      end
      if (wr.hi_en) begin
         valid_in[wr.hi_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         fwd_lo_en_ff <= 1'b0;
         fwd_hi_en_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (wr.lo_en || wr.hi_en) begin
            fwd_lo_en_ff <= wr.lo_en;
            fwd_hi_en_ff <= wr.hi_en;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.lo_en || wr.hi_en) begin
         fwd_lo_addr_ff <= wr.lo_addr;
         fwd_lo_data_ff <= wr.lo_data;
         fwd_hi_addr_ff <= wr.hi_addr;
         fwd_hi_data_ff <= wr.hi_data;
      end
      if (rd_en) begin
         a_addr_ff  <= rd_addr_a;
         b_addr_ff  <= rd_addr_b;
         a_valid_ff <= valid_ff[rd_addr_a];
         b_valid_ff <= valid_ff[rd_addr_b];
      end
   end

   // The write landing on the read edge is missed by the bank; bypass it
   function automatic logic [BYTE_W-1:0] pick(input logic [REG_AW-1:0] addr,
                                              input logic              valid,
                                              input logic [BYTE_W-1:0] even_d,
                                              input logic [BYTE_W-1:0] odd_d,
                                              input logic              lo_en,
                                              input logic [REG_AW-1:0] lo_addr,
                                              input logic [BYTE_W-1:0] lo_data,
                                              input logic              hi_en,
                                              input logic [REG_AW-1:0] hi_addr,
                                              input logic [BYTE_W-1:0] hi_data);
      logic [BYTE_W-1:0] data;
      priority if (hi_en && hi_addr == addr) begin
         data = hi_data;
      end else if (lo_en && lo_addr == addr) begin
         data = lo_data;
      end else if (!valid) begin
         data = '0;
      end else if (addr[0]) begin
         data = odd_d;
      end else begin
         data = even_d;
      end
      return data;
   endfunction

   assign opnd_a = pick(a_addr_ff, a_valid_ff, even_a, odd_a,
                        fwd_lo_en_ff, fwd_lo_addr_ff, fwd_lo_data_ff,
                        fwd_hi_en_ff, fwd_hi_addr_ff, fwd_hi_data_ff);
   assign opnd_b = pick(b_addr_ff, b_valid_ff, even_b, odd_b,
                        fwd_lo_en_ff, fwd_lo_addr_ff, fwd_lo_data_ff,
                        fwd_hi_en_ff, fwd_hi_addr_ff, fwd_hi_data_ff);

endmodule

[src/avradd_alu.sv]
// Add datapath for ADD, ADC and ADIW: sum, new flags and register file writes.
// Depends on avradd_pkg.
module avradd_alu (
   input  logic                               exec,
   input  logic [avradd_pkg::INSTR_W-1:0]     instruction,
   input  logic [avradd_pkg::BYTE_W-1:0]      opnd_a,
   input  logic [avradd_pkg::BYTE_W-1:0]      opnd_b,
   input  avradd_pkg::flags_type              flags_cur,
   output avradd_pkg::result_type             result,
   output avradd_pkg::wr_type                 wr
);
   import avradd_pkg::*;

   op_type              op;
   logic                cin;
   logic [BYTE_W:0]     sum9;
   logic [BYTE_W-1:0]   res8;
   logic [2*BYTE_W-1:0] old16, imm16, res16;
   logic                a3, b3, r3, a7, b7, r7, o15, r15;
   logic                byte_v, word_v;

   always_comb begin
      op    = decode_op(instruction);
      cin   = (op == OP_ADC) ? flags_cur.c : 1'b0;
      sum9  = {1'b0, opnd_a} + {1'b0, opnd_b} + {{BYTE_W{1'b0}}, cin};
      res8  = sum9[BYTE_W-1:0];
      a3    = opnd_a[3];
      b3    = opnd_b[3];
      r3    = res8[3];
      a7    = opnd_a[BYTE_W-1];
      b7    = opnd_b[BYTE_W-1];
      r7    = res8[BYTE_W-1];
      byte_v = (a7 & b7 & ~r7) | (~a7 & ~b7 & r7);

      // ADIW immediate is KK:KKKK from bits 7:6 and 3:0
      old16 = {opnd_b, opnd_a};
      imm16 = {{(2*BYTE_W-6){1'b0}}, instruction[7:6], instruction[3:0]};
      res16 = old16 + imm16;
      o15   = old16[2*BYTE_W-1];
      r15   = res16[2*BYTE_W-1];
      word_v = ~o15 & r15;
   end

   always_comb begin
      result            = '0;
      result.flags      = flags_cur;
      wr                = '0;
      unique case (op)
         OP_ADD, OP_ADC: begin
            result.recognized = 1'b1;
            result.dest_index = {instruction[8], instruction[7:4]};
            result.low_byte   = res8;
            result.flags.h    = (a3 & b3) | (b3 & ~r3) | (~r3 & a3);
            result.flags.v    = byte_v;
            result.flags.n    = r7;
            result.flags.s    = r7 ^ byte_v;
            result.flags.z    = (res8 == '0);
            result.flags.c    = (a7 & b7) | (b7 & ~r7) | (~r7 & a7);
            wr.lo_en          = exec;
            wr.lo_addr        = result.dest_index;
            wr.lo_data        = res8;
         end
         OP_ADIW: begin
            result.recognized = 1'b1;
            result.dest_index = {PAIR_BASE, instruction[5:4], 1'b0};
            result.low_byte   = res16[BYTE_W-1:0];
            result.high_byte  = res16[2*BYTE_W-1:BYTE_W];
            result.wide       = 1'b1;
            result.flags.v    = word_v;
            result.flags.n    = r15;
            result.flags.s    = r15 ^ word_v;
            result.flags.z    = (res16 == '0);
            result.flags.c    = ~r15 & o15;
            wr.lo_en          = exec;
            wr.lo_addr        = result.dest_index;
            wr.lo_data        = res16[BYTE_W-1:0];
            wr.hi_en          = exec;
            wr.hi_addr        = {PAIR_BASE, instruction[5:4], 1'b1};
            wr.hi_data        = res16[2*BYTE_W-1:BYTE_W];
         end
         OP_NONE: begin
            result.recognized = 1'b0;
         end
         default: begin
            result.recognized = 1'b0;
         end
      endcase
   end

endmodule

[src/avr_add_adc_adiw_execute.sv]
// Top level of the AVR add-group execute unit (ADD, ADC, ADIW).
// Depends on avradd_pkg, avradd_regfile and avradd_alu.
//
//   channel   direction   ports                         transfer when
//   req       in          req_instruction               req_valid && req_ready
//   rsp       out         rsp_recognized .. rsp_flag_h  rsp_valid && rsp_ready
//
// One instruction per cycle sustained while rsp_ready stays high. The register banks are read
// on the req transfer into the execute stage, whose add and flag logic lands in the output
// register, which drives rsp_valid.
// Synchronous reset clears the flags and marks all 32 registers as zero at once.
// A stalled rsp holds the output register; the execute stage then holds too and
// req_ready drops only when both are full.
module avr_add_adc_adiw_execute (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [avradd_pkg::INSTR_W-1:0]   req_instruction,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_recognized,
   output logic [avradd_pkg::REG_AW-1:0]    rsp_dest_index,
   output logic [avradd_pkg::BYTE_W-1:0]    rsp_low_byte,
   output logic [avradd_pkg::BYTE_W-1:0]    rsp_high_byte,
   output logic                             rsp_wide,
   output logic                             rsp_flag_c,
   output logic                             rsp_flag_z,
   output logic                             rsp_flag_n,
   output logic                             rsp_flag_v,
   output logic                             rsp_flag_s,
   output logic                             rsp_flag_h
);
   import avradd_pkg::*;

   logic               accept, exec;
   op_type             req_op;
   logic [REG_AW-1:0]  rd_addr_a, rd_addr_b;

   logic               s1_valid_ff, s1_valid_in;
   logic [INSTR_W-1:0] s1_instr_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_data_ff;
   flags_type          flags_ff, flags_in;

   logic [BYTE_W-1:0]  opnd_a, opnd_b;
   result_type         alu_result;
   wr_type             wr;

   // Execute stage retires into the output register when that register is free
   assign exec      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || exec;
   assign accept    = req_valid && req_ready;

   always_comb begin
      req_op    = decode_op(req_instruction);
      rd_addr_a = operand_a_addr(req_instruction, req_op);
      rd_addr_b = operand_b_addr(req_instruction, req_op);
   end

   avradd_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .wr        (wr),
      .opnd_a    (opnd_a),
      .opnd_b    (opnd_b)
   );

   avradd_alu u_alu (
      .exec        (exec),
      .instruction (s1_instr_ff),
      .opnd_a      (opnd_a),
      .opnd_b      (opnd_b),
      .flags_cur   (flags_ff),
      .result      (alu_result),
      .wr          (wr)
   );

   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (exec ? 1'b0 : s1_valid_ff);
      rsp_valid_in = exec ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      flags_in     = exec ? alu_result.flags : flags_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         flags_ff     <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_instr_ff <= req_instruction;
      end
      if (exec) begin
         rsp_data_ff <= alu_result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_recognized = rsp_data_ff.recognized;
   assign rsp_dest_index = rsp_data_ff.dest_index;
   assign rsp_low_byte   = rsp_data_ff.low_byte;
   assign rsp_high_byte  = rsp_data_ff.high_byte;
   assign rsp_wide       = rsp_data_ff.wide;
   assign rsp_flag_c     = rsp_data_ff.flags.c;
   assign rsp_flag_z     = rsp_data_ff.flags.z;
   assign rsp_flag_n     = rsp_data_ff.flags.n;
   assign rsp_flag_v     = rsp_data_ff.flags.v;
   assign rsp_flag_s     = rsp_data_ff.flags.s;
   assign rsp_flag_h     = rsp_data_ff.flags.h;

endmodule

[src/avradd_checker.sv]
// Port-level checks for avr_add_adc_adiw_execute, attached by the bind at the end.
// Depends on avradd_pkg and the top level's port names.
module avradd_port_checks (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_recognized,
   input logic [avradd_pkg::REG_AW-1:0]    rsp_dest_index,
   input logic [avradd_pkg::BYTE_W-1:0]    rsp_low_byte,
   input logic [avradd_pkg::BYTE_W-1:0]    rsp_high_byte,
   input logic                             rsp_wide,
   input logic                             rsp_flag_z,
   input logic                             rsp_flag_n,
   input logic                             rsp_flag_v,
   input logic                             rsp_flag_s
);
   import avradd_pkg::*;

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_low_byte)
         && $stable(rsp_high_byte) && $stable(rsp_dest_index))
      else $error("rsp payload changed while stalled");

   // Unrecognized words write nothing
   a_unrecognized_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_recognized |-> rsp_dest_index == '0 && rsp_low_byte == '0
         && rsp_high_byte == '0 && !rsp_wide)
      else $error("unrecognized word reported a write");

   // Pair writes hit only r24, r26, r28, r30; byte writes leave high byte clear
   a_pair_dest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_recognized |-> (rsp_wide && rsp_dest_index[REG_AW-1 -: 2] == PAIR_BASE
         && !rsp_dest_index[0]) || (!rsp_wide && rsp_high_byte == '0))
      else $error("bad destination for result width");

   // Flags agree with the written result
   a_flags_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_recognized |-> rsp_flag_s == (rsp_flag_n ^ rsp_flag_v)
         && rsp_flag_z == (rsp_low_byte == '0 && rsp_high_byte == '0)
         && rsp_flag_n == (rsp_wide ? rsp_high_byte[BYTE_W-1] : rsp_low_byte[BYTE_W-1]))
      else $error("flags inconsistent with result");

endmodule

bind avr_add_adc_adiw_execute avradd_port_checks u_avradd_port_checks (.*);

[dv/avradd_checker.sv]
// Checker for the AVR add-group execute unit: predicts each result from the accepted
// instruction stream and compares it with what leaves the rsp channel.
// Depends on avradd_pkg for widths, opcode patterns and the result layout.
module avradd_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [avradd_pkg::INSTR_W-1:0] req_instruction,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           rsp_recognized,
   input  logic [avradd_pkg::REG_AW-1:0]  rsp_dest_index,
   input  logic [avradd_pkg::BYTE_W-1:0]  rsp_low_byte,
   input  logic [avradd_pkg::BYTE_W-1:0]  rsp_high_byte,
   input  logic                           rsp_wide,
   input  logic                           rsp_flag_c,
   input  logic                           rsp_flag_z,
   input  logic                           rsp_flag_n,
   input  logic                           rsp_flag_v,
   input  logic                           rsp_flag_s,
   input  logic                           rsp_flag_h,
   output int                             fail_count,
   output int                             pending
);
   import avradd_pkg::*;

   typedef struct {
      logic [INSTR_W-1:0] instr;
      result_type         res;
   } expected_type;

   logic [BYTE_W-1:0] gpr [REG_COUNT];
   flags_type         sreg;
   expected_type      expected_results[$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report_mismatch(input string what);
      $display("%0t checker: %s", $time, what);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want,
                              input logic [INSTR_W-1:0] instr);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0h expected %0h for instruction %h",
                                   name, got, want, instr));
      end
   endtask

   // Advance the register file and flags by one instruction, return the result it yields
   task automatic execute_instruction(input logic [INSTR_W-1:0] instr, output result_type res);
      op_type            kind;
      logic [REG_AW-1:0] rd;
      logic [REG_AW-1:0] rr;
      logic [BYTE_W-1:0] a;
      logic [BYTE_W-1:0] b;
      logic [BYTE_W-1:0] sum;
      logic              carry_in;
      logic [5:0]        imm;
      logic [15:0]       pair_old;
      logic [15:0]       pair_new;
      res = '0;
      if ((instr & ADD_MASK) == ADD_MATCH) begin
         kind = OP_ADD;
      end else if ((instr & ADD_MASK) == ADC_MATCH) begin
         kind = OP_ADC;
      end else if ((instr & ADIW_MASK) == ADIW_MATCH) begin
         kind = OP_ADIW;
      end else begin
         kind = OP_NONE;
      end
      case (kind)
         OP_ADD, OP_ADC: begin
            rd = {instr[8], instr[7:4]};
            rr = {instr[9], instr[3:0]};
            a = gpr[rd];
            b = gpr[rr];
            carry_in = (kind == OP_ADC) ? sreg.c : 1'b0;
            sum = a + b + {7'b0, carry_in};
            sreg.h = (a[3] & b[3]) | (b[3] & ~sum[3]) | (~sum[3] & a[3]);
            sreg.v = (a[7] & b[7] & ~sum[7]) | (~a[7] & ~b[7] & sum[7]);
            sreg.n = sum[7];
            sreg.s = sum[7] ^ sreg.v;
            sreg.z = (sum == '0);
            sreg.c = (a[7] & b[7]) | (b[7] & ~sum[7]) | (~sum[7] & a[7]);
            gpr[rd] = sum;
            res.recognized = 1'b1;
            res.dest_index = rd;
            res.low_byte   = sum;
         end
         OP_ADIW: begin
            rd = {PAIR_BASE, instr[5:4], 1'b0};
            imm = {instr[7:6], instr[3:0]};
            pair_old = {gpr[{rd[4:1], 1'b1}], gpr[rd]};
            pair_new = pair_old + {10'b0, imm};
            // H is left alone by the word add
            sreg.v = ~pair_old[15] & pair_new[15];
            sreg.n = pair_new[15];
            sreg.z = (pair_new == '0);
            sreg.c = ~pair_new[15] & pair_old[15];
            sreg.s = pair_new[15] ^ sreg.v;
            gpr[rd] = pair_new[7:0];
            gpr[{rd[4:1], 1'b1}] = pair_new[15:8];
            res.recognized = 1'b1;
            res.dest_index = rd;
            res.low_byte   = pair_new[7:0];
            res.high_byte  = pair_new[15:8];
            res.wide       = 1'b1;
         end
         default: begin
         end
      endcase
      res.flags = sreg;
   endtask

   always @(posedge clock) begin
      expected_type  entry;
      result_type    res;
      if (reset) begin
         foreach (gpr[i]) gpr[i] = '0;
         sreg = '0;
         expected_results.delete();
         pending <= 0;
      end else begin
         if (req_valid && req_ready) begin
            execute_instruction(req_instruction, res);
            entry.instr = req_instruction;
            entry.res   = res;
            expected_results.push_back(entry);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result transfer with no instruction outstanding");
            end else begin
               entry = expected_results.pop_front();
               check_field("recognized", 8'(rsp_recognized), 8'(entry.res.recognized),
                           entry.instr);
               check_field("dest_index", 8'(rsp_dest_index), 8'(entry.res.dest_index),
                           entry.instr);
               check_field("low_byte", rsp_low_byte, entry.res.low_byte, entry.instr);
               check_field("high_byte", rsp_high_byte, entry.res.high_byte, entry.instr);
               check_field("wide", 8'(rsp_wide), 8'(entry.res.wide), entry.instr);
               check_field("flag_c", 8'(rsp_flag_c), 8'(entry.res.flags.c), entry.instr);
               check_field("flag_z", 8'(rsp_flag_z), 8'(entry.res.flags.z), entry.instr);
               check_field("flag_n", 8'(rsp_flag_n), 8'(entry.res.flags.n), entry.instr);
               check_field("flag_v", 8'(rsp_flag_v), 8'(entry.res.flags.v), entry.instr);
               check_field("flag_s", 8'(rsp_flag_s), 8'(entry.res.flags.s), entry.instr);
               check_field("flag_h", 8'(rsp_flag_h), 8'(entry.res.flags.h), entry.instr);
            end
         end
         pending <= expected_results.size();
      end
   end

endmodule

[dv/tb.sv]
// Testbench top for the AVR add-group execute unit: clock, reset, instruction stimulus
// and rsp flow control. Depends on avradd_pkg, avr_add_adc_adiw_execute and avradd_checker.
module tb;
   import avradd_pkg::*;

   localparam int HOLD_OFF_CYCLES = 60;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [INSTR_W-1:0]   req_instruction;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_recognized;
   logic [REG_AW-1:0]    rsp_dest_index;
   logic [BYTE_W-1:0]    rsp_low_byte;
   logic [BYTE_W-1:0]    rsp_high_byte;
   logic                 rsp_wide;
   logic                 rsp_flag_c;
   logic                 rsp_flag_z;
   logic                 rsp_flag_n;
   logic                 rsp_flag_v;
   logic                 rsp_flag_s;
   logic                 rsp_flag_h;
   int                   fail_count;
   int                   pending;
   int                   sender_idle_pct;
   int                   receiver_stall_pct;
   bit                   hold_off_req;
   bit                   hold_off_done;

   avr_add_adc_adiw_execute i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_instruction (req_instruction),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_recognized  (rsp_recognized),
      .rsp_dest_index  (rsp_dest_index),
      .rsp_low_byte    (rsp_low_byte),
      .rsp_high_byte   (rsp_high_byte),
      .rsp_wide        (rsp_wide),
      .rsp_flag_c      (rsp_flag_c),
      .rsp_flag_z      (rsp_flag_z),
      .rsp_flag_n      (rsp_flag_n),
      .rsp_flag_v      (rsp_flag_v),
      .rsp_flag_s      (rsp_flag_s),
      .rsp_flag_h      (rsp_flag_h)
   );

   avradd_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_instruction (req_instruction),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_recognized  (rsp_recognized),
      .rsp_dest_index  (rsp_dest_index),
      .rsp_low_byte    (rsp_low_byte),
      .rsp_high_byte   (rsp_high_byte),
      .rsp_wide        (rsp_wide),
      .rsp_flag_c      (rsp_flag_c),
      .rsp_flag_z      (rsp_flag_z),
      .rsp_flag_n      (rsp_flag_n),
      .rsp_flag_v      (rsp_flag_v),
      .rsp_flag_s      (rsp_flag_s),
      .rsp_flag_h      (rsp_flag_h),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic [INSTR_W-1:0] alu_word(input logic [INSTR_W-1:0] match,
                                                   input logic [4:0] rd, input logic [4:0] rr);
      return match | {6'b0, rr[4], rd[4], rd[3:0], rr[3:0]};
   endfunction

   function automatic logic [INSTR_W-1:0] adiw_word(input logic [1:0] pair, input logic [5:0] k);
      return ADIW_MATCH | {8'b0, k[5:4], pair, k[3:0]};
   endfunction

   // Mostly well-formed adds with random operands, some noise and corrupted opcodes
   function automatic logic [INSTR_W-1:0] random_instruction();
      int unsigned        pick;
      logic [4:0]         rd;
      logic [4:0]         rr;
      logic [INSTR_W-1:0] word;
      pick = $urandom_range(0, 99);
      rd = 5'($urandom_range(0, 31));
      rr = 5'($urandom_range(0, 31));
      // the pair registers are where fresh values enter the file
      if ($urandom_range(0, 1) == 1) rr = {2'b11, rr[2:0]};
      if (pick < 30) begin
         word = alu_word(ADD_MATCH, rd, rr);
      end else if (pick < 60) begin
         word = alu_word(ADC_MATCH, rd, rr);
      end else if (pick < 85) begin
         word = adiw_word(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)));
      end else if (pick < 93) begin
         word = 16'($urandom_range(0, 65535));
      end else begin
         word = alu_word(ADD_MATCH, rd, rr) ^ (16'h0400 << $urandom_range(0, 5));
      end
      return word;
   endfunction

   task automatic send_instruction(input logic [INSTR_W-1:0] instr);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_instruction <= instr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic run_phase(input int count, input int idle_pct, input int stall_pct);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (count) send_instruction(random_instruction());
   endtask

   // rsp side: random stalls, or one long hold-off when asked
   initial begin
      rsp_ready     = 1'b0;
      hold_off_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req && !hold_off_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_done = 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
         end
      end
   end

   initial begin
      logic [INSTR_W-1:0] directed_words[$];
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_instruction    = '0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_off_req       = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      directed_words.push_back(16'h0000);
      directed_words.push_back(16'hFFFF);
      // walk r25:r24 up to 0xFFFF, then wrap it with ADIW
      repeat (4) directed_words.push_back(adiw_word(2'd0, 6'd63));
      directed_words.push_back(adiw_word(2'd0, 6'd3));
      directed_words.push_back(alu_word(ADD_MATCH, 5'd25, 5'd24));
      directed_words.push_back(adiw_word(2'd0, 6'd1));
      // carry in from the wrap, same register on both sides
      directed_words.push_back(alu_word(ADC_MATCH, 5'd0, 5'd0));
      directed_words.push_back(adiw_word(2'd3, 6'd63));
      directed_words.push_back(adiw_word(2'd1, 6'd0));
      directed_words.push_back(adiw_word(2'd2, 6'd42));
      directed_words.push_back(alu_word(ADD_MATCH, 5'd31, 5'd30));
      directed_words.push_back(alu_word(ADD_MATCH, 5'd30, 5'd30));
      directed_words.push_back(alu_word(ADD_MATCH, 5'd30, 5'd30));
      directed_words.push_back(alu_word(ADC_MATCH, 5'd30, 5'd31));
      directed_words.push_back(alu_word(ADD_MATCH, 5'd16, 5'd30));
      directed_words.push_back(16'h0BFF);
      directed_words.push_back(16'h97FF);
      directed_words.push_back(16'h1FFF);
      directed_words.push_back(16'h2000);
      foreach (directed_words[i]) send_instruction(directed_words[i]);

      run_phase(300, 0, 0);
      run_phase(250, 69, 0);
      run_phase(250, 0, 69);
      run_phase(250, 9, 9);
      hold_off_req = 1'b1;
      run_phase(60, 0, 0);
      run_phase(200, 0, 0);
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb NOT OK");
      $finish;
   end

endmodule
